// File: design/rotor_constraint_row_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Rotor constraint row generator assertion macros
// Shared assertion forms for the checker of the row generator.
// ----------------------------------------------------------------------------
`ifndef ROTOR_CONSTRAINT_ROW_GENERATOR_CORE_DEFINES_SVH
`define ROTOR_CONSTRAINT_ROW_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RCRG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RCRG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rcrg_pkg.sv
// ----------------------------------------------------------------------------
// Rotor constraint row generator package
// Widths, codes, payload types and constant tables shared by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcrg_pkg;

	localparam int MAX_SIDES    = 32;
	localparam int ROTOR_COUNT  = 6;
	localparam int CORDIC_STEPS = 16;
	localparam int JOBQ_DEPTH   = 2;

	localparam int SIDES_W = 6;
	localparam int ROTOR_W = 3;
	localparam int KIND_W  = 3;
	localparam int ANG_W   = 16;
	localparam int COEF_W  = 16;
	localparam int THR_W   = 23;
	localparam int U_W     = 24;
	localparam int STEP_W  = 15;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 23;
	localparam int PON_W   = 29;
	localparam int PH_W    = 33;
	localparam int XY_W    = 34;
	localparam int ITER_W  = $clog2(CORDIC_STEPS);

	localparam logic [IDX_W-1:0] REG_SIDES    = 3'd0;
	localparam logic [IDX_W-1:0] REG_THR_MAX  = 3'd1;
	localparam logic [IDX_W-1:0] REG_TILT_MIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_TILT_MAX = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP     = 3'd4;
	localparam logic [IDX_W-1:0] REG_THR_OFF  = 3'd5;

	localparam logic [KIND_W-1:0] KIND_FACET   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TILT_LO = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TILT_HI = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RATE_HI = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RATE_LO = 3'd4;

	localparam logic signed [PH_W-1:0] PI_Q28      = 33'sd843314857;
	localparam logic signed [PH_W-1:0] HALF_PI_Q28 = 33'sd421657428;
	localparam logic signed [PH_W-1:0] TWO_PI_Q28  = 33'sd1686629714;
	localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic [STEP_W-1:0]      MIN_HALF    = 15'd71;

	localparam int PI_I = 843314857;

	localparam int PON [0:MAX_SIDES] = '{
		0, 0, 0,
		(PI_I + 1) / 3,   (PI_I + 2) / 4,   (PI_I + 2) / 5,   (PI_I + 3) / 6,
		(PI_I + 3) / 7,   (PI_I + 4) / 8,   (PI_I + 4) / 9,   (PI_I + 5) / 10,
		(PI_I + 5) / 11,  (PI_I + 6) / 12,  (PI_I + 6) / 13,  (PI_I + 7) / 14,
		(PI_I + 7) / 15,  (PI_I + 8) / 16,  (PI_I + 8) / 17,  (PI_I + 9) / 18,
		(PI_I + 9) / 19,  (PI_I + 10) / 20, (PI_I + 10) / 21, (PI_I + 11) / 22,
		(PI_I + 11) / 23, (PI_I + 12) / 24, (PI_I + 12) / 25, (PI_I + 13) / 26,
		(PI_I + 13) / 27, (PI_I + 14) / 28, (PI_I + 14) / 29, (PI_I + 15) / 30,
		(PI_I + 15) / 31, (PI_I + 16) / 32
	};

	typedef struct packed {
		logic [ROTOR_W-1:0]       rotor_index;
		logic signed [U_W-1:0]    prev_thrust_x;
		logic signed [U_W-1:0]    prev_thrust_z;
		logic signed [ANG_W-1:0]  prev_tilt_angle;
		logic                     tilt_held;
	} in_t;

	typedef struct packed {
		logic [ROTOR_W-1:0]       row_rotor;
		logic [KIND_W-1:0]        row_kind;
		logic signed [COEF_W-1:0] coef_x;
		logic signed [COEF_W-1:0] coef_z;
		logic [THR_W-1:0]         row_bound;
		logic                     last_row;
	} out_t;

	typedef struct packed {
		logic [SIDES_W-1:0]       polygon_sides;
		logic [THR_W-1:0]         thrust_max;
		logic signed [ANG_W-1:0]  tilt_min_angle;
		logic signed [ANG_W-1:0]  tilt_max_angle;
		logic [STEP_W-1:0]        tilt_step_limit;
		logic [THR_W-1:0]         thrust_off;
	} cfg_t;

	typedef struct packed {
		logic [ROTOR_W-1:0]       rotor;
		logic signed [ANG_W-1:0]  lo;
		logic signed [ANG_W-1:0]  hi;
	} job_t;

	function automatic logic [PON_W-1:0] atan_step(input logic [ITER_W-1:0] i);
		logic [PON_W-1:0] r;
		case (i)
			0: r = 29'd210828714;
			1: r = 29'd124459457;
			2: r = 29'd65760959;
			3: r = 29'd33381290;
			4: r = 29'd16755422;
			5: r = 29'd8385879;
			6: r = 29'd4193963;
			7: r = 29'd2097109;
			8: r = 29'd1048571;
			9: r = 29'd524287;
			default: r = 29'd1 << (5'd28 - 5'(i));
		endcase
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] to_q14(input logic signed [XY_W-1:0] v);
		logic [XY_W-1:0] mag;
		logic [XY_W-1:0] r;
		logic [COEF_W-1:0] c;
		mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
		r = (mag + XY_W'(32768)) >> 16;
		if (r > XY_W'(16384)) begin
			r = XY_W'(16384);
		end
		c = r[COEF_W-1:0];
		return v[XY_W-1] ? $signed(-c) : $signed(c);
	endfunction

	function automatic logic signed [PH_W-1:0] q13_to_q28(input logic signed [ANG_W-1:0] a);
		return $signed({{2{a[ANG_W-1]}}, a, 15'd0});
	endfunction

endpackage

// File: design/rcrg_front.sv
// ----------------------------------------------------------------------------
// Rotor constraint row generator front end
// Takes an input word, checks the thrust magnitude and forms the rate window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcrg_front import rcrg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic push,
	input  in_t  in_word,
	output logic full,
	output logic job_push,
	output job_t job,
	input  logic job_full
);

	typedef enum logic [1:0] {F_IDLE, F_SQ, F_CMP, F_PUSH} fstate_t;

	fstate_t state_q;
	in_t in_q;
	logic signed [2*U_W-1:0] sqx_q, sqz_q;
	logic [2*THR_W-1:0] off2_q;
	logic [STEP_W-1:0] half_q;
	logic [2*U_W:0] mag2;
	logic thr_low;
	logic [STEP_W-1:0] half_raw;
	logic signed [ANG_W:0] lo_w, hi_w;
	logic valid_rotor;

	assign full = (state_q != F_IDLE);
	assign mag2 = {1'b0, sqx_q} + {1'b0, sqz_q};
	assign thr_low = mag2 <= (2*U_W+1)'(off2_q);
	assign half_raw = (in_q.tilt_held || thr_low) ? '0 : cfg.tilt_step_limit;
	assign valid_rotor = in_q.rotor_index < ROTOR_W'(ROTOR_COUNT);

	always_comb begin
		lo_w = $signed({in_q.prev_tilt_angle[ANG_W-1], in_q.prev_tilt_angle})
			- $signed({2'b0, half_q});
		hi_w = $signed({in_q.prev_tilt_angle[ANG_W-1], in_q.prev_tilt_angle})
			+ $signed({2'b0, half_q});
		job.rotor = in_q.rotor_index;
		if (lo_w < $signed({cfg.tilt_min_angle[ANG_W-1], cfg.tilt_min_angle})) begin
			job.lo = cfg.tilt_min_angle;
		end else begin
			job.lo = lo_w[ANG_W-1:0];
		end
		if (hi_w > $signed({cfg.tilt_max_angle[ANG_W-1], cfg.tilt_max_angle})) begin
			job.hi = cfg.tilt_max_angle;
		end else begin
			job.hi = hi_w[ANG_W-1:0];
		end
	end

	assign job_push = (state_q == F_PUSH) && valid_rotor && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						in_q <= in_word;
						state_q <= F_SQ;
					end
				end
				F_SQ: begin
					sqx_q <= in_q.prev_thrust_x * in_q.prev_thrust_x;
					sqz_q <= in_q.prev_thrust_z * in_q.prev_thrust_z;
					off2_q <= cfg.thrust_off * cfg.thrust_off;
					state_q <= F_CMP;
				end
				F_CMP: begin
					half_q <= (half_raw < MIN_HALF) ? MIN_HALF : half_raw;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!valid_rotor || !job_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: design/rcrg_job_queue.sv
// ----------------------------------------------------------------------------
// Rotor constraint row generator job queue
// Short first-in first-out buffer between the front end and the row engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcrg_job_queue import rcrg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	output logic full,
	input  logic rd,
	output job_t rdata,
	output logic empty
);

	localparam int PTR_W = $clog2(JOBQ_DEPTH);
	localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

	job_t mem_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = cnt_q == CNT_W'(JOBQ_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/rcrg_back.sv
// ----------------------------------------------------------------------------
// Rotor constraint row generator row engine
// Runs an iterative CORDIC per row and writes each row to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcrg_back import rcrg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic job_empty,
	input  job_t job,
	output logic job_pop,
	output logic empty,
	input  logic pop,
	output out_t out_word
);

	typedef enum logic [3:0] {
		B_IDLE, B_RED, B_FOLD, B_ITER, B_ROUND, B_MUL, B_BOUND, B_EMIT, B_NEXT
	} bstate_t;

	bstate_t state_q;
	job_t job_q;
	logic phase_cos_q;
	logic [KIND_W-1:0] kind_q;
	logic [SIDES_W-1:0] n_q, facet_q;
	logic [PON_W-1:0] pon_q;
	logic signed [PH_W-1:0] fang_q, ang_q, m_q;
	logic signed [XY_W-1:0] x_q, y_q, cos30_q;
	logic neg_q;
	logic [ITER_W-1:0] iter_q;
	logic signed [COEF_W-1:0] cx_q, cz_q;
	logic [THR_W+31-1:0] prod_q;
	logic [THR_W-1:0] bound_q;
	logic out_valid_q;
	out_t out_q;

	logic [SIDES_W-1:0] n_sat;
	logic signed [PH_W-1:0] m_wrap, m_a, two_pon;
	logic signed [XY_W-1:0] xs, ys, c_fin, s_fin;
	logic [THR_W+32-1:0] bsum;
	logic can_emit;
	logic emit_now;
	out_t row;

	assign empty = !out_valid_q;
	assign out_word = out_q;
	assign job_pop = (state_q == B_IDLE) && !job_empty;
	assign can_emit = !out_valid_q || pop;
	assign emit_now = (state_q == B_EMIT) && can_emit;

	always_comb begin
		if (cfg.polygon_sides < SIDES_W'(3)) begin
			n_sat = SIDES_W'(3);
		end else if (cfg.polygon_sides > SIDES_W'(MAX_SIDES)) begin
			n_sat = SIDES_W'(MAX_SIDES);
		end else begin
			n_sat = cfg.polygon_sides;
		end
		if (ang_q >= TWO_PI_Q28) begin
			m_wrap = ang_q - TWO_PI_Q28;
		end else if (ang_q < 0) begin
			m_wrap = ang_q + TWO_PI_Q28;
		end else begin
			m_wrap = ang_q;
		end
		m_a = (m_q > PI_Q28) ? m_q - TWO_PI_Q28 : m_q;
		two_pon = $signed({3'b0, pon_q, 1'b0});
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		c_fin = neg_q ? -x_q : x_q;
		s_fin = neg_q ? -y_q : y_q;
		bsum = {1'b0, prod_q} + (THR_W+32)'(64'd1 << 29);
		row.row_rotor = job_q.rotor;
		row.row_kind = kind_q;
		row.row_bound = '0;
		row.last_row = 1'b0;
		case (kind_q)
			KIND_FACET: begin
				row.coef_x = cx_q;
				row.coef_z = cz_q;
				row.row_bound = bound_q;
			end
			KIND_TILT_HI, KIND_RATE_HI: begin
				row.coef_x = cx_q;
				row.coef_z = -cz_q;
			end
			KIND_RATE_LO: begin
				row.coef_x = -cx_q;
				row.coef_z = cz_q;
				row.last_row = 1'b1;
			end
			default: begin
				row.coef_x = -cx_q;
				row.coef_z = cz_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q && !emit_now) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						job_q <= job;
						n_q <= n_sat;
						pon_q <= PON_W'(PON[n_sat]);
						ang_q <= PH_W'(PON[n_sat]);
						phase_cos_q <= 1'b1;
						state_q <= B_RED;
					end
				end
				B_RED: begin
					m_q <= m_wrap;
					state_q <= B_FOLD;
				end
				B_FOLD: begin
					if (m_a > HALF_PI_Q28) begin
						m_q <= m_a - PI_Q28;
						neg_q <= 1'b1;
					end else if (m_a < -HALF_PI_Q28) begin
						m_q <= m_a + PI_Q28;
						neg_q <= 1'b1;
					end else begin
						m_q <= m_a;
						neg_q <= 1'b0;
					end
					x_q <= GAIN_Q30;
					y_q <= '0;
					iter_q <= '0;
					state_q <= B_ITER;
				end
				B_ITER: begin
					if (!m_q[PH_W-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						m_q <= m_q - $signed({4'b0, atan_step(iter_q)});
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						m_q <= m_q + $signed({4'b0, atan_step(iter_q)});
					end
					if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
						state_q <= B_ROUND;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				B_ROUND: begin
					if (phase_cos_q) begin
						cos30_q <= c_fin;
						state_q <= B_MUL;
					end else begin
						cx_q <= to_q14(c_fin);
						cz_q <= to_q14(s_fin);
						state_q <= B_EMIT;
					end
				end
				B_MUL: begin
					prod_q <= cfg.thrust_max * cos30_q[30:0];
					state_q <= B_BOUND;
				end
				B_BOUND: begin
					bound_q <= bsum[THR_W+30-1:30];
					phase_cos_q <= 1'b0;
					kind_q <= KIND_FACET;
					facet_q <= '0;
					fang_q <= $signed({4'b0, pon_q});
					ang_q <= $signed({4'b0, pon_q});
					state_q <= B_RED;
				end
				B_EMIT: begin
					if (can_emit) begin
						out_q <= row;
						out_valid_q <= 1'b1;
						state_q <= (kind_q == KIND_RATE_LO) ? B_IDLE : B_NEXT;
					end
				end
				B_NEXT: begin
					state_q <= B_RED;
					case (kind_q)
						KIND_FACET: begin
							if (facet_q + 1'b1 < n_q) begin
								facet_q <= facet_q + 1'b1;
								fang_q <= fang_q + two_pon;
								ang_q <= fang_q + two_pon;
							end else begin
								kind_q <= KIND_TILT_LO;
								ang_q <= q13_to_q28(cfg.tilt_min_angle);
							end
						end
						KIND_TILT_LO: begin
							kind_q <= KIND_TILT_HI;
							ang_q <= q13_to_q28(cfg.tilt_max_angle);
						end
						KIND_TILT_HI: begin
							kind_q <= KIND_RATE_HI;
							ang_q <= q13_to_q28(job_q.hi);
						end
						default: begin
							kind_q <= KIND_RATE_LO;
							ang_q <= q13_to_q28(job_q.lo);
						end
					endcase
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// File: design/rotor_constraint_row_generator_core.sv
// The front end forms a rate window job; the row engine then runs a 16-step CORDIC
// pass for the facet bound and one per row (N facets, then tilt and rate rows).
// The single CORDIC unit in the row engine limits throughput; the front end can take
// a new word while the row engine still works on an earlier one, if the job queue has room.
// Reset: asynchronous, active low; state, pointers, flags and configuration reset, data registers do not.
// ----------------------------------------------------------------------------
// Rotor constraint row generator
// Emits polygon facet, tilt sector and rate sector rows for one rotor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotor_constraint_row_generator_core import rcrg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  in_t               in_word,
	output logic              full,
	output logic              empty,
	input  logic              pop,
	output out_t              out_word,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data
);

	cfg_t cfg_q;
	logic job_push, job_full, job_pop, job_empty;
	job_t job_in, job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polygon_sides <= SIDES_W'(12);
			cfg_q.thrust_max <= THR_W'(2560);
			cfg_q.tilt_min_angle <= '0;
			cfg_q.tilt_max_angle <= ANG_W'(12868);
			cfg_q.tilt_step_limit <= '0;
			cfg_q.thrust_off <= THR_W'(256);
		end else if (wr_en) begin
			case (wr_index)
				REG_SIDES:    cfg_q.polygon_sides <= wr_data[SIDES_W-1:0];
				REG_THR_MAX:  cfg_q.thrust_max <= wr_data[THR_W-1:0];
				REG_TILT_MIN: cfg_q.tilt_min_angle <= wr_data[ANG_W-1:0];
				REG_TILT_MAX: cfg_q.tilt_max_angle <= wr_data[ANG_W-1:0];
				REG_STEP:     cfg_q.tilt_step_limit <= wr_data[STEP_W-1:0];
				REG_THR_OFF:  cfg_q.thrust_off <= wr_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	rcrg_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.push(push), .in_word(in_word), .full(full),
		.job_push(job_push), .job(job_in), .job_full(job_full)
	);

	rcrg_job_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(job_push), .wdata(job_in), .full(job_full),
		.rd(job_pop), .rdata(job_out), .empty(job_empty)
	);

	rcrg_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.job_empty(job_empty), .job(job_out), .job_pop(job_pop),
		.empty(empty), .pop(pop), .out_word(out_word)
	);

endmodule

// File: design/rcrg_checker.sv
// ----------------------------------------------------------------------------
// Rotor constraint row generator checker
// Port-level properties of the row generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotor_constraint_row_generator_core_defines.svh"

module rcrg_checker import rcrg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input out_t out_word
);

	`RCRG_ASSERT_NEXT(a_busy_after_accept, push && !full, full, "front end took a second word")
	`RCRG_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_word), "waiting word changed")
	`RCRG_ASSERT_NOW(a_last_is_rate_lo, !empty && out_word.last_row, out_word.row_kind == KIND_RATE_LO, "last row has wrong kind")
	`RCRG_ASSERT_NOW(a_rotor_range, !empty, out_word.row_rotor < ROTOR_W'(ROTOR_COUNT), "row for unknown rotor")

endmodule

bind rotor_constraint_row_generator_core rcrg_checker u_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full),
	.empty(empty), .pop(pop), .out_word(out_word)
);
